@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ sv/smbrc_pkg.sv @@
package smbrc_pkg;

  // Field widths of the bus side.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ORIGIN_W = 3;
  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned LAT_W    = 7;

  // Block geometry: eight words, aligned.
  localparam int unsigned BLOCK_WORDS = 8;
  localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_WORDS);
  localparam int unsigned BLK_W       = ADDR_W - BLOCK_SHIFT;

  // Bus command codes.
  localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ_EX = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_FLUSH   = 2'd3;

  // Originator ids below this value are cores.
  localparam logic [ORIGIN_W-1:0] NUM_CORES = 3'd4;

  // Read latency after reset.
  localparam logic [LAT_W-1:0] LAT_RESET = 7'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic exec;
    logic mem_rd;
  } smbrc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } smbrc_stat_t;

endpackage

@@ sv/smbrc_ctrl.sv @@
`include "assert_macros.svh"

module smbrc_ctrl import smbrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  output logic        out_valid,
  input  smbrc_stat_t stat,
  output smbrc_cmd_t  cmd
);

  // Controller states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  // A new item may enter while idle or while the previous result is shown.
  assign busy   = !((state_r == S_IDLE) || (state_r == S_RESP));
  assign accept = start && !busy;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath commands.
  always_comb begin
    cmd.clear_step = (state_r == S_CLEAR);
    cmd.capture    = accept;
    cmd.exec       = (state_r == S_EXEC);
    cmd.mem_rd     = (state_r == S_READ);
  end

  assign out_valid = (state_r == S_RESP);

  // An accepted item always moves on to execution.
  `ASSERT_CLK(a_accept_exec, clk, rst_n, accept |=> (state_r == S_EXEC),
              "accepted item did not enter execution")
  // A result is shown only right after the store read.
  `ASSERT_CLK(a_resp_after_read, clk, rst_n, out_valid |-> ($past(state_r) == S_READ),
              "result shown without a store read")

endmodule

@@ sv/smbrc_dpath.sv @@
`include "assert_macros.svh"

module smbrc_dpath import smbrc_pkg::*; #(
  parameter int unsigned MEM_WORDS = 1048576
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [LAT_W-1:0]    cfg_wr_data,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [ORIGIN_W-1:0] in_origin_id,
  input  logic [ADDR_W-1:0]   in_bus_address,
  input  logic [WORD_W-1:0]   in_bus_word,
  input  logic                in_shared_line,
  input  logic                in_grant_to_memory,
  input  smbrc_cmd_t          cmd,
  output smbrc_stat_t         stat,
  output logic                out_drive_valid,
  output logic [ADDR_W-1:0]   out_drive_address,
  output logic [WORD_W-1:0]   out_drive_word,
  output logic                out_drive_shared,
  output logic                out_last_word,
  output logic                out_read_active
);

  localparam int unsigned MEM_AW = $clog2(MEM_WORDS);

  // Word store.
  logic [WORD_W-1:0] mem [0:MEM_WORDS-1];
  logic [WORD_W-1:0] rdata_r;

  // Configuration.
  logic [LAT_W-1:0] lat_cfg_r;

  // Captured bus cycle.
  logic [ACTION_W-1:0] act_r;
  logic [ORIGIN_W-1:0] org_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [WORD_W-1:0]   word_r;
  logic                shr_in_r;
  logic                gnt_r;

  // Read state.
  logic                   pend_r, pend_nxt;
  logic [LAT_W-1:0]       lcnt_r, lcnt_nxt;
  logic [BLK_W-1:0]       blk_r, blk_nxt;
  logic [BLOCK_SHIFT-1:0] widx_r, widx_nxt;
  logic                   shl_r, shl_nxt;

  // Result registers.
  logic              drv_r, drv_nxt;
  logic [ADDR_W-1:0] daddr_r, daddr_nxt;
  logic              dshr_r, dshr_nxt;
  logic              last_r, last_nxt;
  logic              drng_r;

  // Clearing sweep.
  logic [MEM_AW-1:0] clr_cnt_r;

  logic              flush;
  logic [31:0]       addr_ext;
  logic [31:0]       daddr_ext;
  logic              addr_in_rng;
  logic              daddr_in_rng;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  // Flush decode and address range checks.
  assign flush        = (act_r == ACT_FLUSH) && (org_r < NUM_CORES);
  assign addr_ext     = {{(32 - ADDR_W){1'b0}}, addr_r};
  assign daddr_ext    = {{(32 - ADDR_W){1'b0}}, daddr_nxt};
  assign addr_in_rng  = addr_ext < 32'(MEM_WORDS);
  assign daddr_in_rng = daddr_ext < 32'(MEM_WORDS);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_cfg_r <= LAT_RESET;
    end else if (cfg_wr_en) begin
      lat_cfg_r <= cfg_wr_data;
    end
  end

  // Capture the bus cycle at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r    <= in_action;
      org_r    <= in_origin_id;
      addr_r   <= in_bus_address;
      word_r   <= in_bus_word;
      shr_in_r <= in_shared_line;
      gnt_r    <= in_grant_to_memory;
    end
  end

  // One bus cycle: abort on a flush hit, start on a read, then count or drive.
  always_comb begin
    pend_nxt  = pend_r;
    lcnt_nxt  = lcnt_r;
    blk_nxt   = blk_r;
    widx_nxt  = widx_r;
    shl_nxt   = shl_r;
    drv_nxt   = 1'b0;
    daddr_nxt = '0;
    dshr_nxt  = 1'b0;
    last_nxt  = 1'b0;
    if (flush && pend_r && (addr_r[ADDR_W-1:BLOCK_SHIFT] == blk_r)) begin
      pend_nxt = 1'b0;
      lcnt_nxt = '0;
    end
    if (((act_r == ACT_READ) || (act_r == ACT_READ_EX)) && !pend_nxt) begin
      pend_nxt = 1'b1;
      blk_nxt  = addr_r[ADDR_W-1:BLOCK_SHIFT];
      lcnt_nxt = lat_cfg_r;
      widx_nxt = '0;
      shl_nxt  = shr_in_r;
    end
    if (pend_nxt) begin
      if (lcnt_nxt != '0) begin
        lcnt_nxt = lcnt_nxt - LAT_W'(1);
      end else if (gnt_r) begin
        drv_nxt   = 1'b1;
        daddr_nxt = {blk_nxt, widx_nxt};
        dshr_nxt  = shl_nxt;
        if (widx_nxt == BLOCK_SHIFT'(BLOCK_WORDS - 1)) begin
          last_nxt = 1'b1;
          pend_nxt = 1'b0;
        end
        widx_nxt = widx_nxt + BLOCK_SHIFT'(1);
      end
    end
  end

  // Read state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      lcnt_r <= '0;
      blk_r  <= '0;
      widx_r <= '0;
      shl_r  <= 1'b0;
    end else if (cmd.exec) begin
      pend_r <= pend_nxt;
      lcnt_r <= lcnt_nxt;
      blk_r  <= blk_nxt;
      widx_r <= widx_nxt;
      shl_r  <= shl_nxt;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drv_r  <= 1'b0;
      last_r <= 1'b0;
    end else if (cmd.exec) begin
      drv_r  <= drv_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      daddr_r <= daddr_nxt;
      dshr_r  <= dshr_nxt;
      drng_r  <= daddr_in_rng;
    end
  end

  // Clearing sweep counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
    end
  end

  assign stat.clear_last = (clr_cnt_r == MEM_AW'(MEM_WORDS - 1));

  // Store write port: clearing sweep or flush.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_ext[MEM_AW-1:0];
    mem_wdata = word_r;
    if (cmd.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (cmd.exec && flush && addr_in_rng) begin
      mem_we = 1'b1;
    end
  end

  // Store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[daddr_r[MEM_AW-1:0]];
    end
  end

  // Outputs.
  assign out_drive_valid   = drv_r;
  assign out_drive_address = daddr_r;
  assign out_drive_word    = (drv_r && drng_r) ? rdata_r : '0;
  assign out_drive_shared  = dshr_r;
  assign out_last_word     = last_r;
  assign out_read_active   = pend_r;

  // The last word is always a driven word.
  `ASSERT_CLK(a_last_driven, clk, rst_n, last_r |-> drv_r,
              "last word without a driven word")
  // The last word ends the read.
  `ASSERT_CLK(a_last_ends_read, clk, rst_n, last_r |-> !pend_r,
              "read still pending after the last word")
  // No word is driven while the latency count is still running.
  `ASSERT_CLK(a_no_early_drive, clk, rst_n,
              (cmd.exec && pend_r && (lcnt_r != '0) && !flush) |=> !drv_r,
              "word driven before the latency ran out")

endmodule

@@ sv/snooping_memory_block_read_controller_unit.sv @@
// Channel  | Handshake          | Ports
// ---------+--------------------+---------------------------------------------
// input    | start, busy        | in_action, in_origin_id, in_bus_address,
//          |                    | in_bus_word, in_shared_line, in_grant_to_memory
// result   | out_valid (strobe) | out_drive_valid, out_drive_address,
//          |                    | out_drive_word, out_drive_shared,
//          |                    | out_last_word, out_read_active
// config   | cfg_wr_en          | cfg_wr_data (read latency)
//
// Each item passes through execute, store read, then the result cycle, in
// which the next item may already be accepted. A new item is taken only
// while idle or in the result cycle of the previous one, never during its
// execute or store read.
// After reset the store is cleared one word per cycle, all MEM_WORDS words, with
// busy held high; configuration writes are taken throughout.
// The receiver cannot stall: each result is shown for exactly one cycle.

module snooping_memory_block_read_controller_unit import smbrc_pkg::*; #(
  parameter int unsigned MEM_WORDS = 1048576
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [LAT_W-1:0]    cfg_wr_data,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [ORIGIN_W-1:0] in_origin_id,
  input  logic [ADDR_W-1:0]   in_bus_address,
  input  logic [WORD_W-1:0]   in_bus_word,
  input  logic                in_shared_line,
  input  logic                in_grant_to_memory,
  output logic                out_valid,
  output logic                out_drive_valid,
  output logic [ADDR_W-1:0]   out_drive_address,
  output logic [WORD_W-1:0]   out_drive_word,
  output logic                out_drive_shared,
  output logic                out_last_word,
  output logic                out_read_active
);

  smbrc_cmd_t  cmd;
  smbrc_stat_t stat;

  // Sequencer.
  smbrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store, read state and result registers.
  smbrc_dpath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_action          (in_action),
    .in_origin_id       (in_origin_id),
    .in_bus_address     (in_bus_address),
    .in_bus_word        (in_bus_word),
    .in_shared_line     (in_shared_line),
    .in_grant_to_memory (in_grant_to_memory),
    .cmd                (cmd),
    .stat               (stat),
    .out_drive_valid    (out_drive_valid),
    .out_drive_address  (out_drive_address),
    .out_drive_word     (out_drive_word),
    .out_drive_shared   (out_drive_shared),
    .out_last_word      (out_last_word),
    .out_read_active    (out_read_active)
  );

endmodule

@@ tb/sv/smbrc_drive_checker.sv @@
`timescale 1ns / 1ps

// Watches the bus side of the memory controller, predicts what memory drives
// for every accepted item and compares each strobed result with the oldest
// prediction.
module smbrc_drive_checker import smbrc_pkg::*; #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [LAT_W-1:0]    cfg_wr_data,
  input  logic                start,
  input  logic                busy,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [ORIGIN_W-1:0] in_origin_id,
  input  logic [ADDR_W-1:0]   in_bus_address,
  input  logic [WORD_W-1:0]   in_bus_word,
  input  logic                in_shared_line,
  input  logic                in_grant_to_memory,
  input  logic                out_valid,
  input  logic                out_drive_valid,
  input  logic [ADDR_W-1:0]   out_drive_address,
  input  logic [WORD_W-1:0]   out_drive_word,
  input  logic                out_drive_shared,
  input  logic                out_last_word,
  input  logic                out_read_active,
  output int                  errors,
  output int                  outstanding,
  output int                  accepted_items,
  output int                  words_driven,
  output int                  blocks_read
);

  typedef struct packed {
    logic              dv;
    logic [ADDR_W-1:0] da;
    logic [WORD_W-1:0] dw;
    logic              ds;
    logic              lw;
    logic              ra;
  } bus_drive_t;

  // Shadow of the word store; a missing entry reads as zero.
  logic [WORD_W-1:0] store_words [int unsigned];

  // Shadow of the block read state and of the latency register.
  logic              rd_pending;
  logic [LAT_W-1:0]  lat_left;
  logic [BLK_W-1:0]  rd_block;
  logic [3:0]        rd_index;
  logic              rd_shared;
  logic [LAT_W-1:0]  lat_setting;

  bus_drive_t expected_drives[$];

  // One bus cycle as memory sees it: flush write and abort, read start,
  // latency countdown, then one word per granted cycle.
  function automatic bus_drive_t predict_bus_cycle(
    input logic [ACTION_W-1:0] act,
    input logic [ORIGIN_W-1:0] origin,
    input logic [ADDR_W-1:0]   addr,
    input logic [WORD_W-1:0]   word,
    input logic                shared,
    input logic                grant
  );
    bus_drive_t res;
    logic [ADDR_W-1:0] a;
    res = '0;
    if (act == ACT_FLUSH && origin < NUM_CORES) begin
      if (addr < MEM_WORDS) store_words[addr] = word;
      if (rd_pending && addr[ADDR_W-1:BLOCK_SHIFT] == rd_block) begin
        rd_pending = 1'b0;
        lat_left = '0;
      end
    end
    if ((act == ACT_READ || act == ACT_READ_EX) && !rd_pending) begin
      rd_pending = 1'b1;
      rd_block = addr[ADDR_W-1:BLOCK_SHIFT];
      lat_left = lat_setting;
      rd_index = '0;
      rd_shared = shared;
    end
    if (rd_pending) begin
      if (lat_left != '0) begin
        lat_left = lat_left - 1'b1;
      end else if (grant) begin
        a = {rd_block, rd_index[BLOCK_SHIFT-1:0]};
        res.dv = 1'b1;
        res.da = a;
        res.dw = (a < MEM_WORDS && store_words.exists(a)) ? store_words[a] : '0;
        res.ds = rd_shared;
        rd_index = rd_index + 1'b1;
        if (rd_index >= BLOCK_WORDS) begin
          res.lw = 1'b1;
          rd_pending = 1'b0;
        end
      end
    end
    res.ra = rd_pending;
    return res;
  endfunction

  // Results are matched before new items are predicted, so an item accepted
  // on the same edge never pairs with an older result.
  always @(posedge clk) begin
    bus_drive_t got;
    bus_drive_t want;
    if (!rst_n) begin
      store_words.delete();
      expected_drives.delete();
      rd_pending = 1'b0;
      lat_left = '0;
      rd_block = '0;
      rd_index = '0;
      rd_shared = 1'b0;
      lat_setting = LAT_RESET;
      errors = 0;
      accepted_items = 0;
      words_driven = 0;
      blocks_read = 0;
    end else begin
      if (out_valid === 1'b1) begin
        got = {out_drive_valid, out_drive_address, out_drive_word,
               out_drive_shared, out_last_word, out_read_active};
        if (expected_drives.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with no item waiting: dv=%0d addr=%h word=%h",
                     $time, got.dv, got.da, got.dw);
        end else begin
          want = expected_drives.pop_front();
          if (got.dv !== want.dv || got.da !== want.da || got.dw !== want.dw ||
              got.ds !== want.ds || got.lw !== want.lw || got.ra !== want.ra) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: drive mismatch, expected dv=%0d addr=%h word=%h",
                       $time, want.dv, want.da, want.dw);
              $display("  shared=%0d last=%0d active=%0d; got dv=%0d addr=%h",
                       want.ds, want.lw, want.ra, got.dv, got.da);
              $display("  word=%h shared=%0d last=%0d active=%0d",
                       got.dw, got.ds, got.lw, got.ra);
            end
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        want = predict_bus_cycle(in_action, in_origin_id, in_bus_address,
                                 in_bus_word, in_shared_line, in_grant_to_memory);
        expected_drives.push_back(want);
        accepted_items++;
        if (want.dv) words_driven++;
        if (want.lw) blocks_read++;
      end
      if (cfg_wr_en === 1'b1) lat_setting = cfg_wr_data;
    end
    outstanding = expected_drives.size();
  end

endmodule

@@ tb/sv/tb_snooping_memory_block_read_controller_unit.sv @@
`timescale 1ns / 1ps

module tb_snooping_memory_block_read_controller_unit import smbrc_pkg::*;;

  // A small store keeps the clearing pass short and puts addresses beyond
  // the store within reach of the bus.
  localparam int unsigned STORE_WORDS  = 4096;
  localparam int unsigned STORE_BLOCKS = STORE_WORDS / BLOCK_WORDS;
  localparam int unsigned PHASE_ITEMS  = 110;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [LAT_W-1:0]    cfg_wr_data;
  logic                start;
  logic                busy;
  logic [ACTION_W-1:0] in_action;
  logic [ORIGIN_W-1:0] in_origin_id;
  logic [ADDR_W-1:0]   in_bus_address;
  logic [WORD_W-1:0]   in_bus_word;
  logic                in_shared_line;
  logic                in_grant_to_memory;
  logic                out_valid;
  logic                out_drive_valid;
  logic [ADDR_W-1:0]   out_drive_address;
  logic [WORD_W-1:0]   out_drive_word;
  logic                out_drive_shared;
  logic                out_last_word;
  logic                out_read_active;

  int errors;
  int outstanding;
  int accepted_items;
  int words_driven;
  int blocks_read;

  int lat_now;
  int items_sent;
  int latency_writes;
  bit gaps_on;

  snooping_memory_block_read_controller_unit #(
    .MEM_WORDS(STORE_WORDS)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_origin_id       (in_origin_id),
    .in_bus_address     (in_bus_address),
    .in_bus_word        (in_bus_word),
    .in_shared_line     (in_shared_line),
    .in_grant_to_memory (in_grant_to_memory),
    .out_valid          (out_valid),
    .out_drive_valid    (out_drive_valid),
    .out_drive_address  (out_drive_address),
    .out_drive_word     (out_drive_word),
    .out_drive_shared   (out_drive_shared),
    .out_last_word      (out_last_word),
    .out_read_active    (out_read_active)
  );

  smbrc_drive_checker #(
    .MEM_WORDS(STORE_WORDS)
  ) drive_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_origin_id       (in_origin_id),
    .in_bus_address     (in_bus_address),
    .in_bus_word        (in_bus_word),
    .in_shared_line     (in_shared_line),
    .in_grant_to_memory (in_grant_to_memory),
    .out_valid          (out_valid),
    .out_drive_valid    (out_drive_valid),
    .out_drive_address  (out_drive_address),
    .out_drive_word     (out_drive_word),
    .out_drive_shared   (out_drive_shared),
    .out_last_word      (out_last_word),
    .out_read_active    (out_read_active),
    .errors             (errors),
    .outstanding        (outstanding),
    .accepted_items     (accepted_items),
    .words_driven       (words_driven),
    .blocks_read        (blocks_read)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("[snooping_memory_block_read_controller_unit] ERROR");
    $finish;
  end

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int next_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Blocks mostly inside the store, some anywhere on the bus.
  function automatic logic [BLK_W-1:0] pick_block();
    if ($urandom_range(0, 99) < 85) return BLK_W'($urandom_range(0, STORE_BLOCKS - 1));
    return BLK_W'($urandom);
  endfunction

  function automatic logic [ADDR_W-1:0] in_block(input logic [BLK_W-1:0] blk);
    return {blk, {BLOCK_SHIFT{1'b0}}} | ADDR_W'($urandom_range(0, BLOCK_WORDS - 1));
  endfunction

  // Presents one item at a falling edge and holds it until it is taken.
  task automatic send_item(
    input logic [ACTION_W-1:0] act,
    input logic [ORIGIN_W-1:0] origin,
    input logic [ADDR_W-1:0]   addr,
    input logic [WORD_W-1:0]   word,
    input logic                shared,
    input logic                grant
  );
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_action <= act;
    in_origin_id <= origin;
    in_bus_address <= addr;
    in_bus_word <= word;
    in_shared_line <= shared;
    in_grant_to_memory <= grant;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
  endtask

  // Latency changes only once every item has produced its result.
  task automatic set_latency(input int value);
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= LAT_W'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    lat_now = value;
    latency_writes++;
  endtask

  // Seeds a block with flushes, reads it, then runs long enough for the
  // countdown and all eight words, with aborts and other traffic mixed in.
  task automatic run_block_read();
    logic [BLK_W-1:0] blk;
    int nflush;
    int body;
    int r;
    blk = pick_block();
    gaps_on = ($urandom_range(0, 3) != 0);
    nflush = $urandom_range(0, 4);
    repeat (nflush)
      send_item(ACT_FLUSH, ORIGIN_W'($urandom_range(0, 3)), in_block(blk), $urandom,
                1'($urandom), 1'($urandom));
    send_item($urandom_range(0, 1) ? ACT_READ : ACT_READ_EX, ORIGIN_W'($urandom),
              in_block(blk), $urandom, 1'($urandom), 1'($urandom));
    body = lat_now + 10 + $urandom_range(0, 6);
    repeat (body) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_item(ACT_NONE, ORIGIN_W'($urandom), ADDR_W'($urandom), $urandom,
                  1'($urandom), $urandom_range(0, 99) < 80);
      end else if (r < 80) begin
        // Flush elsewhere, usually alongside a driven word.
        send_item(ACT_FLUSH, ORIGIN_W'($urandom_range(0, 3)), in_block(pick_block()),
                  $urandom, 1'($urandom), $urandom_range(0, 99) < 80);
      end else if (r < 87) begin
        // Flush into the block from a non-core id must not abort.
        send_item(ACT_FLUSH, ORIGIN_W'($urandom_range(4, 7)), in_block(blk), $urandom,
                  1'($urandom), 1'($urandom));
      end else if (r < 93) begin
        send_item($urandom_range(0, 1) ? ACT_READ : ACT_READ_EX, ORIGIN_W'($urandom),
                  in_block(pick_block()), $urandom, 1'($urandom), 1'($urandom));
      end else if (r < 96) begin
        // Core flush into the pending block aborts the read.
        send_item(ACT_FLUSH, ORIGIN_W'($urandom_range(0, 3)), in_block(blk), $urandom,
                  1'($urandom), 1'($urandom));
      end else begin
        send_item(ACTION_W'($urandom), ORIGIN_W'($urandom), ADDR_W'($urandom), $urandom,
                  1'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic run_noise();
    int n;
    n = $urandom_range(1, 5);
    gaps_on = ($urandom_range(0, 3) != 0);
    repeat (n)
      send_item(ACTION_W'($urandom), ORIGIN_W'($urandom), ADDR_W'($urandom), $urandom,
                1'($urandom), 1'($urandom));
  endtask

  // Stimulus: reset, directed bus cycles, then random phases per latency.
  initial begin
    int lat_plan[6];
    int target;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    start = 1'b0;
    in_action = ACT_NONE;
    in_origin_id = '0;
    in_bus_address = '0;
    in_bus_word = '0;
    in_shared_line = 1'b0;
    in_grant_to_memory = 1'b0;
    lat_now = LAT_RESET;
    items_sent = 0;
    latency_writes = 0;
    gaps_on = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Flushes at the field extremes, from cores and from other ids.
    send_item(ACT_FLUSH, 3'd0, 20'h00000, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_item(ACT_FLUSH, 3'd3, 20'h00001, 32'h1234_5678, 1'b1, 1'b1);
    send_item(ACT_FLUSH, 3'd7, 20'h00002, 32'hDEAD_BEEF, 1'b0, 1'b1);
    send_item(ACT_FLUSH, 3'd4, 20'h00003, 32'hA5A5_5A5A, 1'b1, 1'b0);
    // Beyond the store, then the last word inside it.
    send_item(ACT_FLUSH, 3'd1, 20'hFFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_item(ACT_FLUSH, 3'd2, ADDR_W'(STORE_WORDS - 1), 32'h0F0F_F0F0, 1'b0, 1'b0);
    send_item(ACT_NONE, 3'd7, 20'hFFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // Read at reset latency, a read while busy, then non-core and core flushes.
    send_item(ACT_READ_EX, 3'd0, 20'hFFFFF, 32'h0, 1'b1, 1'b1);
    send_item(ACT_READ, 3'd1, 20'h00000, 32'h0, 1'b0, 1'b1);
    send_item(ACT_FLUSH, 3'd5, 20'hFFFF8, 32'h5555_AAAA, 1'b0, 1'b1);
    send_item(ACT_FLUSH, 3'd0, 20'hFFFFC, 32'h0, 1'b0, 1'b1);

    // Zero latency: the first word goes out in the start cycle.
    set_latency(0);
    send_item(ACT_READ, 3'd2, 20'h00005, 32'h0, 1'b1, 1'b1);
    send_item(ACT_NONE, 3'd0, 20'h00000, 32'h0, 1'b0, 1'b1);
    send_item(ACT_NONE, 3'd0, 20'h00000, 32'h0, 1'b0, 1'b0);
    // Flush to another block in the same cycle as a driven word.
    send_item(ACT_FLUSH, 3'd1, 20'h00040, 32'hCAFE_F00D, 1'b0, 1'b1);
    repeat (5) send_item(ACT_NONE, 3'd0, 20'h00000, 32'h0, 1'b0, 1'b1);

    lat_plan = '{16, 1, 127, 64, 0, 0};
    lat_plan[4] = $urandom_range(2, 63);
    lat_plan[5] = $urandom_range(2, 126);
    foreach (lat_plan[p]) begin
      set_latency(lat_plan[p]);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 80) run_block_read();
        else run_noise();
      end
    end

    // Drain and let any stray result show up.
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Covered %0d bus cycles over %0d read latency settings, 0 and 127 among them.",
             accepted_items, latency_writes + 1);
    $display("Memory drove %0d words and finished %0d block reads.",
             words_driven, blocks_read);
    if (errors == 0 && outstanding == 0) begin
      $display("[snooping_memory_block_read_controller_unit] OK");
    end else begin
      $display("[snooping_memory_block_read_controller_unit] ERROR");
    end
    $finish;
  end

endmodule
